>>> sv/ihc_pkg.sv
// Shared types and constants for the IPv4 header check block.
package ihc_pkg;

  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [3:0] MIN_IHL      = 4'd5;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [15:0] CSUM_GOOD = 16'hFFFF;

  localparam int WORD_W  = 16;
  localparam int COUNT_W = 5;

  typedef enum logic [3:0] {
    VERDICT_ICMP          = 4'd0,
    VERDICT_TCP           = 4'd1,
    VERDICT_UDP           = 4'd2,
    VERDICT_BAD_VERSION   = 4'd3,
    VERDICT_SHORT_IHL     = 4'd4,
    VERDICT_TTL_ZERO      = 4'd5,
    VERDICT_BAD_CHECKSUM  = 4'd6,
    VERDICT_NOT_OURS      = 4'd7,
    VERDICT_UNKNOWN_PROTO = 4'd8
  } ihc_verdict_t;

  typedef struct packed {
    ihc_verdict_t  verdict;
    logic [31:0]   source_address;
    logic [15:0]   total_length;
    logic [15:0]   identification;
    logic [7:0]    protocol;
  } ihc_result_t;

endpackage

>>> sv/ihc_parse.sv
// Header word parser: running checksum, field latches and verdict selection.
module ihc_parse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wen,
  input  logic [31:0]              cfg_wdata,
  input  logic                     word_acc,
  input  logic [ihc_pkg::WORD_W-1:0] word,
  input  logic                     first,
  output logic                     res_valid,
  output ihc_pkg::ihc_result_t     res
);

  localparam logic [ihc_pkg::COUNT_W-1:0] IDX_LENGTH = 5'd1;
  localparam logic [ihc_pkg::COUNT_W-1:0] IDX_IDENT  = 5'd2;
  localparam logic [ihc_pkg::COUNT_W-1:0] IDX_TTL    = 5'd4;
  localparam logic [ihc_pkg::COUNT_W-1:0] IDX_SRC_HI = 5'd6;
  localparam logic [ihc_pkg::COUNT_W-1:0] IDX_SRC_LO = 5'd7;
  localparam logic [ihc_pkg::COUNT_W-1:0] IDX_DST_HI = 5'd8;
  localparam logic [ihc_pkg::COUNT_W-1:0] IDX_DST_LO = 5'd9;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  logic [31:0] local_address_r;
  logic        active_r, active_nxt;
  logic [ihc_pkg::COUNT_W-1:0] word_count_r, word_count_nxt;
  logic [ihc_pkg::COUNT_W-1:0] header_words_r, header_words_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] ident_r, ident_nxt;

  always_comb begin
    active_nxt       = active_r;
    word_count_nxt   = word_count_r;
    header_words_nxt = header_words_r;
    sum_nxt          = sum_r;
    ttl_nxt          = ttl_r;
    proto_nxt        = proto_r;
    src_nxt          = src_r;
    dst_nxt          = dst_r;
    length_nxt       = length_r;
    ident_nxt        = ident_r;
    res_valid        = 1'b0;
    res              = '0;

    if (word_acc) begin
      if (first) begin
        // A first word always abandons whatever header was in progress.
        active_nxt       = 1'b0;
        word_count_nxt   = '0;
        header_words_nxt = '0;
        sum_nxt          = '0;
        ttl_nxt          = '0;
        proto_nxt        = '0;
        src_nxt          = '0;
        dst_nxt          = '0;
        length_nxt       = '0;
        ident_nxt        = '0;
        if (word[15:12] != ihc_pkg::IPV4_VERSION) begin
          res_valid   = 1'b1;
          res.verdict = ihc_pkg::VERDICT_BAD_VERSION;
        end else if (word[11:8] < ihc_pkg::MIN_IHL) begin
          res_valid   = 1'b1;
          res.verdict = ihc_pkg::VERDICT_SHORT_IHL;
        end else begin
          header_words_nxt = {word[11:8], 1'b0};
          sum_nxt          = word;
          word_count_nxt   = 5'd1;
          active_nxt       = 1'b1;
        end
      end else if (active_r) begin
        sum_nxt = oc_add(sum_r, word);
        unique case (word_count_r)
          IDX_LENGTH: length_nxt = word;
          IDX_IDENT:  ident_nxt  = word;
          IDX_TTL: begin
            ttl_nxt   = word[15:8];
            proto_nxt = word[7:0];
          end
          IDX_SRC_HI: src_nxt[31:16] = word;
          IDX_SRC_LO: src_nxt[15:0]  = word;
          IDX_DST_HI: dst_nxt[31:16] = word;
          IDX_DST_LO: dst_nxt[15:0]  = word;
          default: ;
        endcase
        word_count_nxt = word_count_r + 5'd1;

        if (word_count_nxt >= header_words_r) begin
          // The closing word may itself carry a latched field, so the verdict
          // looks at the updated values.
          active_nxt         = 1'b0;
          res_valid          = 1'b1;
          res.source_address = src_nxt;
          res.total_length   = length_nxt;
          res.identification = ident_nxt;
          res.protocol       = proto_nxt;
          priority if (ttl_nxt == 8'd0) begin
            res.verdict = ihc_pkg::VERDICT_TTL_ZERO;
          end else if (sum_nxt != ihc_pkg::CSUM_GOOD) begin
            res.verdict = ihc_pkg::VERDICT_BAD_CHECKSUM;
          end else if (dst_nxt != local_address_r) begin
            res.verdict = ihc_pkg::VERDICT_NOT_OURS;
          end else if (proto_nxt == ihc_pkg::PROTO_ICMP) begin
            res.verdict = ihc_pkg::VERDICT_ICMP;
          end else if (proto_nxt == ihc_pkg::PROTO_TCP) begin
            res.verdict = ihc_pkg::VERDICT_TCP;
          end else if (proto_nxt == ihc_pkg::PROTO_UDP) begin
            res.verdict = ihc_pkg::VERDICT_UDP;
          end else begin
            res.verdict = ihc_pkg::VERDICT_UNKNOWN_PROTO;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= '0;
      active_r        <= 1'b0;
      word_count_r    <= '0;
      header_words_r  <= '0;
    end else begin
      if (cfg_wen) begin
        local_address_r <= cfg_wdata;
      end
      active_r       <= active_nxt;
      word_count_r   <= word_count_nxt;
      header_words_r <= header_words_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    ttl_r    <= ttl_nxt;
    proto_r  <= proto_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    length_r <= length_nxt;
    ident_r  <= ident_nxt;
  end

endmodule

>>> sv/ihc_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register.
module ihc_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ihc_pkg::ihc_result_t push_data,
  output logic                 can_accept,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ihc_pkg::ihc_result_t out_data
);

  logic                 main_valid_r, main_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  ihc_pkg::ihc_result_t main_r, main_nxt;
  ihc_pkg::ihc_result_t skid_r, skid_nxt;
  logic                 pop;

  assign pop        = main_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // No push can arrive while the skid entry is occupied.
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> sv/ipv4_header_check.sv
// A verdict is registered in the output buffer before it is offered on out_tvalid.
// Throughput: one header word per cycle while in_tready is high; the checksum add is combinational.
// Results pass through a two-entry buffer, so input stalls only once two verdicts wait.
// Reset (synchronous, rst_n low) empties the buffer, drops any header in progress
// and clears the local address to zero.
module ipv4_header_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,   // local_address
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // header_word[15:0]
  input  logic [0:0]  in_tuser,    // first_word[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // source_address[31:0], total_length[47:32],
                                   // identification[63:48], protocol[71:64]
  output logic [3:0]  out_tuser    // verdict[3:0]
);

  logic                 word_acc;
  logic                 res_valid;
  ihc_pkg::ihc_result_t res;
  ihc_pkg::ihc_result_t out_res;

  assign word_acc = in_tvalid && in_tready;

  ihc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .word_acc  (word_acc),
    .word      (in_tdata),
    .first     (in_tuser[0]),
    .res_valid (res_valid),
    .res       (res)
  );

  ihc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tuser = out_res.verdict;
  assign out_tdata = {out_res.protocol, out_res.identification,
                      out_res.total_length, out_res.source_address};

endmodule

>>> sv/ihc_checker.sv
// Port-level checks for the IPv4 header check block, bound to the top level.
module ihc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // A result that is not taken stays on offer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before transfer");

  // Verdict codes beyond unknown protocol are never produced.
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ihc_pkg::VERDICT_UNKNOWN_PROTO)
    else $error("verdict code out of range");

  // Early drops come before any field has been latched.
  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ihc_pkg::VERDICT_BAD_VERSION ||
                   out_tuser == ihc_pkg::VERDICT_SHORT_IHL) |-> out_tdata == '0)
    else $error("early drop carries nonzero fields");

  // A first word with a wrong version is reported in the next cycle when the output is free.
  a_bad_version: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] && !out_tvalid &&
    (in_tdata[15:12] != ihc_pkg::IPV4_VERSION)
    |=> out_tvalid && out_tuser == ihc_pkg::VERDICT_BAD_VERSION)
    else $error("bad version not reported at once");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind ipv4_header_check ihc_checker u_ihc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> verif/ipv4_header_check_tb.sv
// Self-checking testbench for ipv4_header_check: header streams against a software parser.
module ipv4_header_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 380;
  localparam int DRAIN_CYCLES  = 16;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [15:0] data;
    logic        first;
  } hdr_word_t;

  // Running state of the software header parser.
  typedef struct packed {
    logic [4:0]  count;
    logic [4:0]  length_words;
    logic [15:0] csum;
    logic        busy;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] tot_len;
    logic [15:0] ident;
  } hdr_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [3:0]  out_tuser;

  hdr_word_t            word_queue[$];
  ihc_pkg::ihc_result_t verdict_queue[$];
  hdr_state_t           parse_state = '0;
  logic [31:0]          own_address = '0;
  logic                 word_taken = 1'b0;
  int                   errors = 0;
  int                   words_queued = 0;
  int                   stall_cycles = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   holds_asked = 0;
  int                   holds_granted = 0;
  int                   hold_left = 0;

  ipv4_header_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Advances the parser by one header word and records any verdict it yields.
  task automatic predict_word(input logic [15:0] w, input logic first);
    ihc_pkg::ihc_result_t r;
    logic                 done;
    r = '0;
    done = 1'b0;
    if (first) begin
      parse_state = '0;
      if (w[15:12] != ihc_pkg::IPV4_VERSION) begin
        r.verdict = ihc_pkg::VERDICT_BAD_VERSION;
        done = 1'b1;
      end else if (w[11:8] < ihc_pkg::MIN_IHL) begin
        r.verdict = ihc_pkg::VERDICT_SHORT_IHL;
        done = 1'b1;
      end else begin
        parse_state.length_words = {w[11:8], 1'b0};
        parse_state.csum = csum_add(16'd0, w);
        parse_state.count = 5'd1;
        parse_state.busy = 1'b1;
      end
    end else if (parse_state.busy) begin
      parse_state.csum = csum_add(parse_state.csum, w);
      case (parse_state.count)
        5'd1: parse_state.tot_len = w;
        5'd2: parse_state.ident = w;
        5'd4: begin
          parse_state.ttl = w[15:8];
          parse_state.proto = w[7:0];
        end
        5'd6: parse_state.src[31:16] = w;
        5'd7: parse_state.src[15:0] = w;
        5'd8: parse_state.dst[31:16] = w;
        5'd9: parse_state.dst[15:0] = w;
        default: ;
      endcase
      parse_state.count = parse_state.count + 5'd1;
      if (parse_state.count >= parse_state.length_words) begin
        parse_state.busy = 1'b0;
        done = 1'b1;
        if (parse_state.ttl == 8'd0)
          r.verdict = ihc_pkg::VERDICT_TTL_ZERO;
        else if (parse_state.csum != ihc_pkg::CSUM_GOOD)
          r.verdict = ihc_pkg::VERDICT_BAD_CHECKSUM;
        else if (parse_state.dst != own_address)
          r.verdict = ihc_pkg::VERDICT_NOT_OURS;
        else if (parse_state.proto == ihc_pkg::PROTO_ICMP)
          r.verdict = ihc_pkg::VERDICT_ICMP;
        else if (parse_state.proto == ihc_pkg::PROTO_TCP)
          r.verdict = ihc_pkg::VERDICT_TCP;
        else if (parse_state.proto == ihc_pkg::PROTO_UDP)
          r.verdict = ihc_pkg::VERDICT_UDP;
        else
          r.verdict = ihc_pkg::VERDICT_UNKNOWN_PROTO;
        r.source_address = parse_state.src;
        r.total_length = parse_state.tot_len;
        r.identification = parse_state.ident;
        r.protocol = parse_state.proto;
      end
    end
    if (done)
      verdict_queue.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Input monitor, parser update, result check and watchdog.
  always @(posedge clk) begin
    ihc_pkg::ihc_result_t want;
    word_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_wen)
        own_address = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (verdict_queue.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, got %0d", $time, out_tuser);
          errors++;
        end else begin
          want = verdict_queue.pop_front();
          check_field("verdict", {28'd0, want.verdict}, {28'd0, out_tuser});
          check_field("source_address", want.source_address, out_tdata[31:0]);
          check_field("total_length", {16'd0, want.total_length}, {16'd0, out_tdata[47:32]});
          check_field("identification", {16'd0, want.identification},
                      {16'd0, out_tdata[63:48]});
          check_field("protocol", {24'd0, want.protocol}, {24'd0, out_tdata[71:64]});
        end
      end
      if (in_tvalid && in_tready)
        predict_word(in_tdata, in_tuser[0]);
      if (!(in_tvalid && in_tready) && !(out_tvalid && out_tready) &&
          (word_queue.size() > 0 || verdict_queue.size() > 0))
        stall_cycles++;
      else
        stall_cycles = 0;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("** ipv4_header_check: FAILED **");
        $finish;
      end
    end
  end

  // Word sender: once offered, a word stays on the bus until its transfer.
  always @(negedge clk) begin
    logic offer;
    if (word_taken)
      word_queue.delete(0);
    offer = rst_n && (word_queue.size() > 0) &&
            ((in_tvalid && !word_taken) || ($urandom_range(99) >= send_idle_pct));
    in_tvalid <= offer;
    if (offer) begin
      in_tdata <= word_queue[0].data;
      in_tuser <= word_queue[0].first;
    end
  end

  // Verdict receiver, with a long hold-off on request to back the block up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_word(input logic [15:0] w, input logic first);
    word_queue.push_back({w, first});
    words_queued++;
  endtask

  // Builds a complete header; the checksum is made good unless corruption is asked for.
  task automatic queue_header(input logic [3:0] ihl, input logic [7:0] ttl,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst, input bit corrupt);
    logic [15:0] words[$];
    logic [15:0] sum;
    words = {};
    words.push_back({ihc_pkg::IPV4_VERSION, ihl, 8'($urandom)});
    words.push_back(16'($urandom));
    words.push_back(16'($urandom));
    words.push_back(16'($urandom));
    words.push_back({ttl, proto});
    words.push_back(16'd0);
    words.push_back(src[31:16]);
    words.push_back(src[15:0]);
    words.push_back(dst[31:16]);
    words.push_back(dst[15:0]);
    for (int i = 10; i < 2 * ihl; i++)
      words.push_back(16'($urandom));
    sum = 16'd0;
    foreach (words[i])
      sum = csum_add(sum, words[i]);
    words[5] = ~sum;
    if (corrupt)
      words[5] = words[5] ^ 16'($urandom_range(65535, 1));
    foreach (words[i])
      push_word(words[i], i == 0);
  endtask

  task automatic queue_random_header(input logic [31:0] addr);
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] dst;
    ihl = ($urandom_range(99) < 70) ? 4'd5 : 4'($urandom_range(15, 6));
    ttl = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
    case ($urandom_range(3))
      0: proto = ihc_pkg::PROTO_ICMP;
      1: proto = ihc_pkg::PROTO_TCP;
      2: proto = ihc_pkg::PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    dst = ($urandom_range(99) < 85) ? addr : 32'($urandom);
    queue_header(ihl, ttl, proto, 32'($urandom), dst, $urandom_range(99) < 15);
  endtask

  // Stray words, early drops and headers cut short by a fresh first word.
  task automatic queue_noise();
    logic [3:0] ver;
    int         n;
    case ($urandom_range(4))
      0: begin
        n = $urandom_range(3, 1);
        repeat (n) push_word(16'($urandom), 1'b0);
      end
      1: begin
        ver = 4'($urandom_range(14));
        if (ver >= ihc_pkg::IPV4_VERSION)
          ver = ver + 4'd1;
        push_word({ver, 12'($urandom)}, 1'b1);
      end
      2: push_word({ihc_pkg::IPV4_VERSION, 4'($urandom_range(4)), 8'($urandom)}, 1'b1);
      3: begin
        push_word({ihc_pkg::IPV4_VERSION, 4'($urandom_range(15, 5)), 8'($urandom)}, 1'b1);
        n = $urandom_range(8, 1);
        repeat (n) push_word(16'($urandom), 1'b0);
      end
      default: push_word(16'($urandom), 1'($urandom));
    endcase
  endtask

  task automatic queue_directed(input logic [31:0] addr);
    push_word(16'hFFFF, 1'b0);   // ignored while no header is open
    push_word(16'hFFFF, 1'b1);
    push_word(16'h0000, 1'b1);
    push_word(16'h4400, 1'b1);
    push_word(16'h4000, 1'b1);
    // This header is abandoned when the next one starts.
    push_word(16'h4500, 1'b1);
    push_word(16'h1234, 1'b0);
    push_word(16'h5678, 1'b0);
    queue_header(4'd5, 8'hFF, ihc_pkg::PROTO_ICMP, 32'hFFFF_FFFF, addr, 1'b0);
  endtask

  task automatic wait_until_drained();
    while (word_queue.size() > 0 || verdict_queue.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [31:0] addr,
                           input bit directed, input bit hold);
    int start;
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= addr;
    @(negedge clk);
    cfg_wen <= 1'b0;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold)
      holds_asked++;
    if (directed)
      queue_directed(addr);
    start = words_queued;
    while (words_queued - start < PHASE_WORDS) begin
      if ($urandom_range(99) < 75)
        queue_random_header(addr);
      else
        queue_noise();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    run_phase(0, 0, 32'h0000_0000, 1'b1, 1'b0);
    run_phase(55, 0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    run_phase(0, 55, 32'($urandom), 1'b0, 1'b0);
    run_phase(34, 34, 32'($urandom), 1'b0, 1'b0);
    run_phase(0, 0, 32'($urandom), 1'b0, 1'b1);
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("** ipv4_header_check: PASSED **");
    else
      $display("** ipv4_header_check: FAILED **");
    $finish;
  end

endmodule

>>> ipv4_header_check.f
sv/ihc_pkg.sv
sv/ihc_parse.sv
sv/ihc_out_buf.sv
sv/ipv4_header_check.sv
sv/ihc_checker.sv
verif/ipv4_header_check_tb.sv
